/* hw/rtl/pcpe_pkg.sv */
package pcpe_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int POS_W   = 32;
    localparam int COEF_W  = 48;
    localparam int ENTRY_W = 6;
    localparam int CFG_W   = 7;
    localparam int ROW_W   = POS_W + 4 * COEF_W;

    localparam int QUEUE_DEPTH = 2;

    localparam int MUL_W  = COEF_W / 2;
    localparam int PART_W = MUL_W + POS_W;
    localparam int FULL_W = COEF_W + POS_W;
    localparam int FRAC_SHIFT = 16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [COEF_W-1:0] VAL_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] VAL_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [FULL_W-1:0] RND_HALF = FULL_W'(32'h0000_8000);

    typedef struct packed {
        logic                is_query;
        logic [ENTRY_W-1:0]  slot;
        logic [POS_W-1:0]    pos;
        logic [COEF_W-1:0]   coef_a;
        logic [COEF_W-1:0]   coef_b;
        logic [COEF_W-1:0]   coef_c;
        logic [COEF_W-1:0]   coef_d;
    } t_cmd;

endpackage

/* hw/rtl/pcpe_ram.sv */
module pcpe_ram #(
    parameter int WIDTH = pcpe_pkg::ROW_W,
    parameter int DEPTH = pcpe_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pcpe_front.sv */
module pcpe_front #(
    parameter int TABLE_DEPTH = pcpe_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_action,
    input  logic [pcpe_pkg::ENTRY_W-1:0]          i_entry_index,
    input  logic [pcpe_pkg::POS_W-1:0]            i_record_start,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_constant,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_linear,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_quadratic,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_cubic,
    input  logic [pcpe_pkg::POS_W-1:0]            i_query_position,
    output logic                                  o_cmd_valid,
    output pcpe_pkg::t_cmd                        o_cmd,
    input  logic                                  i_cmd_ready
);

    import pcpe_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic keep;

    // A load aimed past the end of the table is taken and dropped here.
    assign keep = (i_action == ACT_QUERY) || (32'(i_entry_index) < 32'(TABLE_DEPTH));

    always_comb begin
        n_cmd.is_query = (i_action == ACT_QUERY);
        n_cmd.slot     = i_entry_index;
        n_cmd.pos      = (i_action == ACT_QUERY) ? i_query_position : i_record_start;
        n_cmd.coef_a   = i_coef_constant;
        n_cmd.coef_b   = i_coef_linear;
        n_cmd.coef_c   = i_coef_quadratic;
        n_cmd.coef_d   = i_coef_cubic;
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* hw/rtl/pcpe_queue.sv */
module pcpe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  pcpe_pkg::t_cmd  i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output pcpe_pkg::t_cmd  o_pop_cmd
);

    import pcpe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slots[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wp] <= i_push_cmd;
        end
    end

endmodule

/* hw/rtl/pcpe_back.sv */
module pcpe_back #(
    parameter int TABLE_DEPTH = pcpe_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pcpe_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                  i_cmd_valid,
    input  pcpe_pkg::t_cmd                        i_cmd,
    output logic                                  o_cmd_ready,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [pcpe_pkg::COEF_W-1:0]    o_profile_value,
    output logic                                  o_found,
    output logic                                  o_saturated
);

    import pcpe_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_ABS    = 4'd2;
    localparam logic [3:0] ST_MUL_LO = 4'd3;
    localparam logic [3:0] ST_MUL_HI = 4'd4;
    localparam logic [3:0] ST_SUM    = 4'd5;
    localparam logic [3:0] ST_SCALE  = 4'd6;
    localparam logic [3:0] ST_ADD    = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    localparam logic [1:0] LAST_STEP = 2'd2;

    logic [3:0]        r_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [AW-1:0]     r_addr;
    logic              r_chk;
    logic              r_chk_last;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_ds;
    logic [COEF_W-1:0] r_acc;
    logic [COEF_W-1:0] r_coef_a;
    logic [COEF_W-1:0] r_coef_b;
    logic [COEF_W-1:0] r_coef_c;
    logic [1:0]        r_step;
    logic              r_found;
    logic              r_sat;
    logic              r_neg;
    logic [COEF_W-1:0] r_mag;
    logic [PART_W-1:0] r_p0;
    logic [PART_W-1:0] r_p1;
    logic [63:0]       r_prod;

    logic              r_out_valid;
    logic [COEF_W-1:0] r_out_value;
    logic              r_out_found;
    logic              r_out_sat;

    logic [CW-1:0]     cnt_eff;
    logic              ram_we;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;
    logic [POS_W-1:0]  rd_start;
    logic [COEF_W-1:0] rd_a;
    logic [COEF_W-1:0] rd_b;
    logic [COEF_W-1:0] rd_c;
    logic [COEF_W-1:0] rd_d;
    logic [MUL_W-1:0]  mul_half;
    logic [PART_W-1:0] mul_prod;
    logic [FULL_W-1:0] full;
    logic [63:0]       limit;
    logic              over;
    logic [COEF_W-1:0] mag_sat;
    logic [COEF_W-1:0] coef_sel;
    logic [COEF_W:0]   sum;
    logic              sum_ovf;
    logic [COEF_W-1:0] sum_sat;
    logic              out_free;

    assign cnt_eff = (32'(r_cfg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_cfg);

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign ram_we      = (r_state == ST_IDLE) && i_cmd_valid && !i_cmd.is_query;
    assign ram_wdata   = {i_cmd.pos, i_cmd.coef_a, i_cmd.coef_b, i_cmd.coef_c, i_cmd.coef_d};

    pcpe_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.slot)),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign {rd_start, rd_a, rd_b, rd_c, rd_d} = ram_rdata;

    assign mul_half = (r_state == ST_MUL_HI) ? r_mag[COEF_W-1:MUL_W] : r_mag[MUL_W-1:0];
    assign mul_prod = PART_W'(mul_half) * PART_W'(r_ds);

    assign full    = {r_p1, {MUL_W{1'b0}}} + FULL_W'(r_p0) + RND_HALF;
    assign limit   = r_neg ? 64'(VAL_MIN) : 64'(VAL_MAX);
    assign over    = (r_prod > limit);
    assign mag_sat = over ? limit[COEF_W-1:0] : r_prod[COEF_W-1:0];

    always_comb begin
        case (r_step)
            2'd0:    coef_sel = r_coef_c;
            2'd1:    coef_sel = r_coef_b;
            default: coef_sel = r_coef_a;
        endcase
    end

    assign sum     = {r_acc[COEF_W-1], r_acc} + {coef_sel[COEF_W-1], coef_sel};
    assign sum_ovf = sum[COEF_W] ^ sum[COEF_W-1];
    assign sum_sat = sum_ovf ? (sum[COEF_W] ? VAL_MIN : VAL_MAX) : sum[COEF_W-1:0];

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && i_cmd.is_query) begin
                        r_state <= (cnt_eff == '0) ? ST_FINISH : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (r_chk && (rd_start <= r_pos)) begin
                        r_state <= ST_ABS;
                    end else if (r_chk && r_chk_last) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_ABS:    r_state <= ST_MUL_LO;
                ST_MUL_LO: r_state <= ST_MUL_HI;
                ST_MUL_HI: r_state <= ST_SUM;
                ST_SUM:    r_state <= ST_SCALE;
                ST_SCALE:  r_state <= ST_ADD;
                ST_ADD: begin
                    r_state <= (r_step == LAST_STEP) ? ST_FINISH : ST_ABS;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pos      <= i_cmd.pos;
                r_addr     <= AW'(cnt_eff - CW'(1));
                r_chk      <= 1'b0;
                r_chk_last <= 1'b0;
                r_found    <= 1'b0;
                r_sat      <= 1'b0;
                r_acc      <= '0;
            end
            ST_SEARCH: begin
                r_addr     <= r_addr - AW'(1);
                r_chk      <= 1'b1;
                r_chk_last <= (r_addr == '0);
                if (r_chk && (rd_start <= r_pos)) begin
                    r_ds     <= r_pos - rd_start;
                    r_acc    <= rd_d;
                    r_coef_a <= rd_a;
                    r_coef_b <= rd_b;
                    r_coef_c <= rd_c;
                    r_step   <= 2'd0;
                    r_found  <= 1'b1;
                end
            end
            ST_ABS: begin
                r_neg <= r_acc[COEF_W-1];
                r_mag <= r_acc[COEF_W-1] ? (COEF_W'(0) - r_acc) : r_acc;
            end
            ST_MUL_LO: r_p0 <= mul_prod;
            ST_MUL_HI: r_p1 <= mul_prod;
            ST_SUM:    r_prod <= full[FULL_W-1:FRAC_SHIFT];
            ST_SCALE: begin
                r_acc <= r_neg ? (COEF_W'(0) - mag_sat) : mag_sat;
                if (over) begin
                    r_sat <= 1'b1;
                end
            end
            ST_ADD: begin
                r_acc  <= sum_sat;
                r_step <= r_step + 2'd1;
                if (sum_ovf) begin
                    r_sat <= 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_out_value <= r_acc;
                    r_out_found <= r_found;
                    r_out_sat   <= r_sat;
                end
            end
            default: r_chk <= 1'b0;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_profile_value = r_out_value;
    assign o_found         = r_out_found;
    assign o_saturated     = r_out_sat;

endmodule

/* hw/rtl/piecewise_cubic_profile_eval.sv */
// Channel   Direction  Handshake                 Words
// input     in         i_in_valid / o_in_ready   load a record or query a position
// output    out        o_out_valid / i_out_ready one value per query, none per load
// config    in         i_cfg_we                  records_in_use, taken at once
//
// A load passes the input register and the queue and is written into the table once the evaluator is idle.
// A query scans the records in use from the highest slot downward: the single table read
// port scans one record a cycle, and one 24 by 32 bit multiplier serves all three Horner steps.
// A two-word queue lets new words be taken while the evaluator works or a result waits.
// Reset clears control state only; table rows hold nothing until they are loaded.
module piecewise_cubic_profile_eval #(
    parameter int TABLE_DEPTH = pcpe_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pcpe_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_action,
    input  logic [pcpe_pkg::ENTRY_W-1:0]          i_entry_index,
    input  logic [pcpe_pkg::POS_W-1:0]            i_record_start,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_constant,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_linear,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_quadratic,
    input  logic signed [pcpe_pkg::COEF_W-1:0]    i_coef_cubic,
    input  logic [pcpe_pkg::POS_W-1:0]            i_query_position,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [pcpe_pkg::COEF_W-1:0]    o_profile_value,
    output logic                                  o_found,
    output logic                                  o_saturated
);

    import pcpe_pkg::*;

    logic fr_valid;
    logic fr_ready;
    t_cmd fr_cmd;
    logic bk_valid;
    logic bk_ready;
    t_cmd bk_cmd;

    pcpe_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_entry_index    (i_entry_index),
        .i_record_start   (i_record_start),
        .i_coef_constant  (i_coef_constant),
        .i_coef_linear    (i_coef_linear),
        .i_coef_quadratic (i_coef_quadratic),
        .i_coef_cubic     (i_coef_cubic),
        .i_query_position (i_query_position),
        .o_cmd_valid      (fr_valid),
        .o_cmd            (fr_cmd),
        .i_cmd_ready      (fr_ready)
    );

    pcpe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_cmd   (fr_cmd),
        .o_pop_valid  (bk_valid),
        .i_pop_ready  (bk_ready),
        .o_pop_cmd    (bk_cmd)
    );

    pcpe_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_valid     (bk_valid),
        .i_cmd           (bk_cmd),
        .o_cmd_ready     (bk_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_profile_value (o_profile_value),
        .o_found         (o_found),
        .o_saturated     (o_saturated)
    );

endmodule

/* verif/piecewise_cubic_profile_eval_tb.sv */
module piecewise_cubic_profile_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpe_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        logic               action;
        logic [ENTRY_W-1:0] slot;
        logic [POS_W-1:0]   start;
        logic [COEF_W-1:0]  a;
        logic [COEF_W-1:0]  b;
        logic [COEF_W-1:0]  c;
        logic [COEF_W-1:0]  d;
        logic [POS_W-1:0]   pos;
    } t_profile_word;

    typedef struct packed {
        logic [COEF_W-1:0] value;
        logic              found;
        logic              saturated;
    } t_profile_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_W-1:0]          i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_action = ACT_LOAD;
    logic [ENTRY_W-1:0]        i_entry_index = '0;
    logic [POS_W-1:0]          i_record_start = '0;
    logic signed [COEF_W-1:0]  i_coef_constant = '0;
    logic signed [COEF_W-1:0]  i_coef_linear = '0;
    logic signed [COEF_W-1:0]  i_coef_quadratic = '0;
    logic signed [COEF_W-1:0]  i_coef_cubic = '0;
    logic [POS_W-1:0]          i_query_position = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [COEF_W-1:0]  o_profile_value;
    logic                      o_found;
    logic                      o_saturated;

    piecewise_cubic_profile_eval dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_entry_index    (i_entry_index),
        .i_record_start   (i_record_start),
        .i_coef_constant  (i_coef_constant),
        .i_coef_linear    (i_coef_linear),
        .i_coef_quadratic (i_coef_quadratic),
        .i_coef_cubic     (i_coef_cubic),
        .i_query_position (i_query_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_profile_value  (o_profile_value),
        .o_found          (o_found),
        .o_saturated      (o_saturated)
    );

    t_profile_word   pending_words[$];
    t_profile_result expected_profile_q[$];

    logic [POS_W-1:0]  start_tab [DEPTH];
    logic [COEF_W-1:0] constant_tab [DEPTH];
    logic [COEF_W-1:0] linear_tab [DEPTH];
    logic [COEF_W-1:0] quadratic_tab [DEPTH];
    logic [COEF_W-1:0] cubic_tab [DEPTH];
    logic [CFG_W-1:0]  searched_records = '0;

    logic [POS_W-1:0]  plan_start [DEPTH];

    t_profile_word cur_word;
    int send_wait = 0;
    int recv_wait = 0;
    int send_idle_max = 0;
    int recv_idle_max = 0;
    int words_planned = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int results_checked = 0;
    int not_found_seen = 0;
    int saturated_seen = 0;
    int settings_used = 0;
    int mismatches = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [COEF_W:0] scale_by_distance(input logic [COEF_W-1:0] acc,
                                                         input logic [POS_W-1:0] ds);
        logic [COEF_W-1:0] mag;
        logic [81:0]       prod;
        logic [81:0]       lim;
        logic              sat;
        mag = acc[COEF_W-1] ? (~acc + 1'b1) : acc;
        prod = (82'(mag) * 82'(ds) + 82'd32768) >> FRAC_SHIFT;
        lim = acc[COEF_W-1] ? 82'(VAL_MIN) : 82'(VAL_MAX);
        sat = 1'b0;
        if (prod > lim) begin
            prod = lim;
            sat = 1'b1;
        end
        if (acc[COEF_W-1]) begin
            return {sat, ~prod[COEF_W-1:0] + 1'b1};
        end
        return {sat, prod[COEF_W-1:0]};
    endfunction

    function automatic logic [COEF_W:0] add_saturating(input logic [COEF_W-1:0] x,
                                                      input logic [COEF_W-1:0] y);
        logic [COEF_W:0] sum;
        sum = {x[COEF_W-1], x} + {y[COEF_W-1], y};
        if (!sum[COEF_W] && sum[COEF_W-1]) begin
            return {1'b1, VAL_MAX};
        end
        if (sum[COEF_W] && !sum[COEF_W-1]) begin
            return {1'b1, VAL_MIN};
        end
        return {1'b0, sum[COEF_W-1:0]};
    endfunction

    function automatic t_profile_result evaluate_profile(input logic [POS_W-1:0] pos);
        t_profile_result res;
        int              n;
        int              pick;
        logic [POS_W-1:0] ds;
        logic [COEF_W:0] step;
        logic            sat;
        res = '0;
        pick = -1;
        n = (searched_records > DEPTH) ? DEPTH : int'(searched_records);
        for (int i = n - 1; i >= 0; i--) begin
            if (pick < 0 && start_tab[i] <= pos) begin
                pick = i;
            end
        end
        if (pick >= 0) begin
            ds = pos - start_tab[pick];
            step = scale_by_distance(cubic_tab[pick], ds);
            sat = step[COEF_W];
            step = add_saturating(step[COEF_W-1:0], quadratic_tab[pick]);
            sat |= step[COEF_W];
            step = scale_by_distance(step[COEF_W-1:0], ds);
            sat |= step[COEF_W];
            step = add_saturating(step[COEF_W-1:0], linear_tab[pick]);
            sat |= step[COEF_W];
            step = scale_by_distance(step[COEF_W-1:0], ds);
            sat |= step[COEF_W];
            step = add_saturating(step[COEF_W-1:0], constant_tab[pick]);
            sat |= step[COEF_W];
            res.value = step[COEF_W-1:0];
            res.found = 1'b1;
            res.saturated = sat;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [COEF_W-1:0] got,
                                   input logic [COEF_W-1:0] want);
        if (mismatches < 100) begin
            $display("%0t ns: mismatch on %s, got %h, expected %h", $time, field, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (cur_word.action == ACT_QUERY) begin
                    expected_profile_q.insert(expected_profile_q.size(),
                                              evaluate_profile(cur_word.pos));
                    queries_sent++;
                end else begin
                    start_tab[cur_word.slot] = cur_word.start;
                    constant_tab[cur_word.slot] = cur_word.a;
                    linear_tab[cur_word.slot] = cur_word.b;
                    quadratic_tab[cur_word.slot] = cur_word.c;
                    cubic_tab[cur_word.slot] = cur_word.d;
                    loads_sent++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_action <= cur_word.action;
                    i_entry_index <= cur_word.slot;
                    i_record_start <= cur_word.start;
                    i_coef_constant <= cur_word.a;
                    i_coef_linear <= cur_word.b;
                    i_coef_quadratic <= cur_word.c;
                    i_coef_cubic <= cur_word.d;
                    i_query_position <= cur_word.pos;
                    send_wait = $urandom_range(0, send_idle_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_profile_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_profile_q.size() == 0) begin
                    report_mismatch("result with no query waiting", o_profile_value, '0);
                end else begin
                    want = expected_profile_q.pop_front();
                    results_checked++;
                    if (!want.found) not_found_seen++;
                    if (want.saturated) saturated_seen++;
                    if (o_profile_value !== want.value)
                        report_mismatch("profile_value", o_profile_value, want.value);
                    if (o_found !== want.found)
                        report_mismatch("found", COEF_W'(o_found), COEF_W'(want.found));
                    if (o_saturated !== want.saturated)
                        report_mismatch("saturated", COEF_W'(o_saturated),
                                        COEF_W'(want.saturated));
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [COEF_W-1:0] rand_bits48();
        return COEF_W'({$urandom, $urandom});
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] v;
        v = rand_bits48();
        case ($urandom_range(0, 9))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2, 3: v = v;
            default: v = $signed(v) >>> $urandom_range(8, 47);
        endcase
        return v;
    endfunction

    function automatic void push_load(input logic [ENTRY_W-1:0] slot,
                                      input logic [POS_W-1:0] start,
                                      input logic [COEF_W-1:0] a, b, c, d);
        t_profile_word w;
        w.action = ACT_LOAD;
        w.slot = slot;
        w.start = start;
        w.a = a;
        w.b = b;
        w.c = c;
        w.d = d;
        w.pos = $urandom;
        pending_words.insert(pending_words.size(), w);
        plan_start[slot] = start;
        words_planned++;
    endfunction

    function automatic void push_query(input logic [POS_W-1:0] pos);
        t_profile_word w;
        w.action = ACT_QUERY;
        w.slot = ENTRY_W'($urandom);
        w.start = $urandom;
        w.a = rand_bits48();
        w.b = rand_bits48();
        w.c = rand_bits48();
        w.d = rand_bits48();
        w.pos = pos;
        pending_words.insert(pending_words.size(), w);
        words_planned++;
    endfunction

    function automatic logic [POS_W-1:0] pick_query_position(input int n);
        int k;
        int r;
        k = (n > 0) ? $urandom_range(0, n - 1) : 0;
        r = $urandom_range(0, 99);
        if (n > 0 && r < 60) begin
            return plan_start[k] + ($urandom >> $urandom_range(0, 31));
        end
        if (n > 0 && r < 75) begin
            return plan_start[k] - $urandom_range(0, 1);
        end
        if (r < 90) begin
            return $urandom;
        end
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    function automatic void relayout(input int m);
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] spacing;
        bit               ascending;
        base = $urandom >> $urandom_range(0, 8);
        spacing = POS_W'($urandom_range(1, 65535)) << $urandom_range(0, 14);
        ascending = 1'($urandom_range(0, 1));
        for (int k = 0; k < m; k++) begin
            push_load(ENTRY_W'(k),
                      ascending ? base + POS_W'(k) * spacing
                                : (($urandom_range(0, 3) == 0) ? base : $urandom),
                      rand_coef(), rand_coef(), rand_coef(), rand_coef());
        end
    endfunction

    task automatic wait_until_idle();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || i_in_valid || expected_profile_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_records_in_use(input logic [CFG_W-1:0] count);
        wait_until_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        searched_records = count;
        settings_used++;
    endtask

    task automatic set_idling(input int mode);
        send_idle_max = (mode == 1 || mode == 3) ? 14 : 0;
        recv_idle_max = (mode == 2 || mode == 3) ? 14 : 0;
    endtask

    initial begin
        int fixed_counts[6];
        int count;
        int n;
        int phase;
        fixed_counts = '{64, 127, 1, 0, 65, 2};
        phase = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(3);

        // With the register at its reset value nothing is searched.
        push_query('0);
        push_query('1);
        push_load(ENTRY_W'(0), 32'h0000_0000, 48'h0001_0000_0000, 48'h0001_0000_0000,
                  '0, '0);
        push_load(ENTRY_W'(1), 32'h0001_0000, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        push_load(ENTRY_W'(2), 32'h0002_0000, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        push_load(ENTRY_W'(3), 32'h0003_0000, '0, '0, '0, '1);
        push_load(ENTRY_W'(4), 32'h0004_0000, 48'd5, 48'd3, '1, 48'd1);
        push_load(ENTRY_W'(5), 32'h8000_0000, rand_coef(), rand_coef(), rand_coef(),
                  rand_coef());
        push_load(ENTRY_W'(6), 32'hFFFF_0000, rand_coef(), rand_coef(), rand_coef(),
                  rand_coef());
        push_load(ENTRY_W'(7), 32'hFFFF_FFFF, 48'h1234_5678_9ABC, '0, '0, '0);
        push_load(ENTRY_W'(63), 32'hFFFF_FFFF, '1, '1, '1, '1);

        write_records_in_use(CFG_W'(8));
        push_query(32'h0000_0000);
        push_query(32'h0000_FFFF);
        push_query(32'h0001_0000);
        push_query(32'h0001_8000);
        push_query(32'h0002_FFFF);
        push_query(32'h0003_8000);
        push_query(32'h0004_0001);
        push_query(32'h7FFF_FFFF);
        push_query(32'hFFFF_FFFE);
        push_query(32'hFFFF_FFFF);

        write_records_in_use(CFG_W'(1));
        push_query(32'hFFFF_FFFF);

        while (words_planned < 1600) begin
            if (phase < 6) begin
                count = fixed_counts[phase];
            end else begin
                case ($urandom_range(0, 3))
                    0: count = 64;
                    1: count = $urandom_range(65, 127);
                    default: count = $urandom_range(1, 63);
                endcase
            end
            write_records_in_use(CFG_W'(count));
            set_idling((phase == 2) ? 0 : (phase == 3) ? 3 : $urandom_range(0, 3));
            n = (count > DEPTH) ? DEPTH : count;
            // The first layout fills the whole table, so no later search sees an empty slot.
            relayout((n > 4) ? n : 4);
            for (int j = 0; j < 100; j++) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_load(ENTRY_W'($urandom),
                              $urandom_range(0, 1) ? plan_start[$urandom_range(0, DEPTH - 1)]
                                                     + $urandom_range(0, 65535)
                                                   : $urandom,
                              rand_coef(), rand_coef(), rand_coef(), rand_coef());
                end else begin
                    push_query(pick_query_position(n));
                end
            end
            phase++;
        end

        wait_until_idle();
        repeat (100) @(posedge i_clk);
        $display("%0d words sent: %0d record loads and %0d queries over %0d register settings.",
                 loads_sent + queries_sent, loads_sent, queries_sent, settings_used);
        $display("%0d results checked, %0d with no record found and %0d clamped.",
                 results_checked, not_found_seen, saturated_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* piecewise_cubic_profile_eval.f */
hw/rtl/pcpe_pkg.sv
hw/rtl/pcpe_ram.sv
hw/rtl/pcpe_front.sv
hw/rtl/pcpe_queue.sv
hw/rtl/pcpe_back.sv
hw/rtl/piecewise_cubic_profile_eval.sv
verif/piecewise_cubic_profile_eval_tb.sv
